// File: rtl/lvtsa_pkg.sv
// Shared types and constants for the latest-value transmit slot arbiter.
// No dependencies.
package lvtsa_pkg;

    localparam int NUM_SLOTS_DEF = 4;

    localparam int FUNC_W   = 2;
    localparam int SLOT_W   = 4;
    localparam int ID_W     = 11;
    localparam int DATA_W   = 64;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 32;
    localparam int FRAME_W  = ID_W + DATA_W;

    // request function codes
    localparam logic [FUNC_W-1:0] FUNC_SUBMIT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUMP   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REJECT = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_SLOT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_RESTORE = 2'd3;

    typedef logic [FRAME_W-1:0] t_frame;

endpackage

// File: rtl/lvtsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lvtsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/latest_value_tx_slot_arbiter_top.sv
// Top level of the latest-value transmit slot arbiter.
// Depends on lvtsa_pkg and lvtsa_ram (frame store).
//
// Usage: a request (submit, pump or reject) is taken at every rising edge
// where start is high and busy is low; busy never rises, so one request can
// be issued every clock cycle. Its result appears on the o_* result ports
// in the next cycle, for one cycle, flagged by o_done. The receiver
// cannot stall: whatever is on the result ports while o_done is high must be
// captured then. Frames (id and payload) live in a small RAM with registered
// read data; a pump reads the chosen slot at acceptance and the frame
// shows up in the result cycle. Pending marks, the round-robin pointer, the
// last emitted frame and both wrapping counters are flip-flops, so a request
// always sees the effect of the one before it.
module latest_value_tx_slot_arbiter_top #(
    parameter int NUM_SLOTS = lvtsa_pkg::NUM_SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [lvtsa_pkg::FUNC_W-1:0]    i_func,
    input  logic [lvtsa_pkg::SLOT_W-1:0]    i_slot,
    input  logic [lvtsa_pkg::ID_W-1:0]      i_frame_id,
    input  logic [lvtsa_pkg::DATA_W-1:0]    i_frame_data,
    output logic                            o_done,
    output logic [lvtsa_pkg::STATUS_W-1:0]  o_status,
    output logic                            o_out_valid,
    output logic [lvtsa_pkg::SLOT_W-1:0]    o_out_slot,
    output logic [lvtsa_pkg::ID_W-1:0]      o_out_id,
    output logic [lvtsa_pkg::DATA_W-1:0]    o_out_data,
    output logic [lvtsa_pkg::CNT_W-1:0]     o_overwrite_count,
    output logic [lvtsa_pkg::CNT_W-1:0]     o_error_count
);

    import lvtsa_pkg::*;

    localparam int PTR_W = $clog2(NUM_SLOTS);

    // control / bookkeeping state
    logic [NUM_SLOTS-1:0] r_pending;
    logic [PTR_W-1:0]     r_ptr;
    logic                 r_held_valid;
    logic [PTR_W-1:0]     r_held_slot;
    t_frame               r_held_frame;
    logic [CNT_W-1:0]     r_overwrites;
    logic [CNT_W-1:0]     r_errors;

    // result cycle registers
    logic                 r_done;
    logic [STATUS_W-1:0]  r_status;
    logic                 r_emit;
    logic [PTR_W-1:0]     r_emit_slot;

    logic                 n_accept;
    logic                 n_slot_ok;
    logic                 n_hit;
    logic [PTR_W-1:0]     n_found;
    logic [PTR_W-1:0]     n_ptr;
    t_frame               n_held_frame;
    logic [STATUS_W-1:0]  n_status;
    logic                 n_emit;

    logic                 ram_we;
    logic [PTR_W-1:0]     ram_waddr;
    t_frame               ram_wdata;
    t_frame               ram_rdata;

    assign busy     = 1'b0;  // no request is ever held off
    assign n_accept = start && !busy;
    assign n_slot_ok = ({1'b0, i_slot} < (SLOT_W+1)'(NUM_SLOTS));

    // rotating priority pick: first pending slot at or after r_ptr
    always_comb begin
        logic [PTR_W:0] v_idx;
        n_hit   = 1'b0;
        n_found = '0;
        for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
            v_idx = (PTR_W+1)'(r_ptr) + (PTR_W+1)'(k);
            if (v_idx >= (PTR_W+1)'(NUM_SLOTS)) begin
                v_idx = v_idx - (PTR_W+1)'(NUM_SLOTS);
            end
            if (r_pending[v_idx[PTR_W-1:0]]) begin
                n_hit   = 1'b1;
                n_found = v_idx[PTR_W-1:0];
            end
        end
    end

    assign n_ptr = (n_found == PTR_W'(NUM_SLOTS - 1)) ? '0 : n_found + 1'b1;

    // result status and emit flag of the request on the inputs
    always_comb begin
        n_status = ST_OK;
        case (i_func)
            FUNC_SUBMIT: begin
                if (!n_slot_ok) begin
                    n_status = ST_BAD_SLOT;
                end
            end
            FUNC_PUMP: begin
                if (!n_hit) begin
                    n_status = ST_EMPTY;
                end
            end
            FUNC_REJECT: begin
                if (!r_held_valid) begin
                    n_status = ST_NO_RESTORE;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    assign n_emit = n_accept && (i_func == FUNC_PUMP) && n_hit;

    // the frame just emitted is still on the RAM read port in its result cycle
    assign n_held_frame = r_emit ? ram_rdata : r_held_frame;

    // RAM write: a submit stores the new frame, a reject restores the held one
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = i_slot[PTR_W-1:0];
        ram_wdata = {i_frame_id, i_frame_data};
        if (n_accept) begin
            case (i_func)
                FUNC_SUBMIT: begin
                    ram_we = n_slot_ok;
                end
                FUNC_REJECT: begin
                    ram_we    = r_held_valid;
                    ram_waddr = r_held_slot;
                    ram_wdata = n_held_frame;
                end
                default: begin
                    ram_we = 1'b0;
                end
            endcase
        end
    end

    lvtsa_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (NUM_SLOTS)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (n_found),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending    <= '0;
            r_ptr        <= '0;
            r_held_valid <= 1'b0;
            r_held_slot  <= '0;
            r_overwrites <= '0;
            r_errors     <= '0;
            r_done       <= 1'b0;
            r_status     <= ST_OK;
            r_emit       <= 1'b0;
            r_emit_slot  <= '0;
        end else begin
            r_done <= n_accept;
            r_emit <= n_emit;
            if (n_accept) begin
                r_status <= n_status;
                case (i_func)
                    FUNC_SUBMIT: begin
                        if (n_slot_ok) begin
                            if (r_pending[i_slot[PTR_W-1:0]]) begin
                                r_overwrites <= r_overwrites + 1'b1;
                            end
                            r_pending[i_slot[PTR_W-1:0]] <= 1'b1;
                        end
                    end
                    FUNC_PUMP: begin
                        if (n_hit) begin
                            r_emit_slot        <= n_found;
                            r_pending[n_found] <= 1'b0;
                            r_ptr              <= n_ptr;
                            r_held_valid       <= 1'b1;
                            r_held_slot        <= n_found;
                        end
                    end
                    FUNC_REJECT: begin
                        if (r_held_valid) begin
                            r_pending[r_held_slot] <= 1'b1;
                            r_errors               <= r_errors + 1'b1;
                            r_held_valid           <= 1'b0;
                        end
                    end
                    default: begin
                        r_held_valid <= r_held_valid;
                    end
                endcase
            end
        end
    end

    // copy of the last emitted frame (id and payload), taken in its result cycle
    always_ff @(posedge i_clk) begin
        r_held_frame <= n_held_frame;
    end

    assign o_done            = r_done;
    assign o_status          = r_status;
    assign o_out_valid       = r_emit;
    assign o_out_slot        = r_emit ? SLOT_W'(r_emit_slot) : '0;
    assign o_out_id          = r_emit ? ram_rdata[FRAME_W-1 -: ID_W] : '0;
    assign o_out_data        = r_emit ? ram_rdata[DATA_W-1:0] : '0;
    assign o_overwrite_count = r_overwrites;
    assign o_error_count     = r_errors;

    // result strobe follows its request in the next cycle
    a_done_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_accept |=> o_done)
        else $error("result strobe missing after accepted request");

    // an emitted frame always carries ok status
    a_emit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_done && o_status == ST_OK))
        else $error("emission without ok status");

    // a pump emission clears the pending mark of its slot
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_accept && i_func == FUNC_PUMP && n_hit) |=> !r_pending[$past(n_found)])
        else $error("emitted slot still pending");

    // error count moves only on a successful reject
    a_err_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_errors != $past(r_errors)) |->
            ($past(n_accept) && $past(i_func) == FUNC_REJECT && $past(r_held_valid)))
        else $error("error counter changed without a restore");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for latest_value_tx_slot_arbiter_top: directed and random
// submit / pump / reject requests, results checked against an in-bench arbiter model.
// Depends on lvtsa_pkg and the arbiter RTL.
module tb_top;
    import lvtsa_pkg::*;

    localparam int SLOTS = NUM_SLOTS_DEF;

    // The package names three request codes; the fourth is legal on the port
    // and must behave as a no-op.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // One result as seen on the o_* ports.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                valid;
        logic [SLOT_W-1:0]   slot;
        logic [ID_W-1:0]     id;
        logic [DATA_W-1:0]   data;
        logic [CNT_W-1:0]    ovw;
        logic [CNT_W-1:0]    errs;
    } t_arb_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [FUNC_W-1:0]   i_func;
    logic [SLOT_W-1:0]   i_slot;
    logic [ID_W-1:0]     i_frame_id;
    logic [DATA_W-1:0]   i_frame_data;
    logic                o_done;
    logic [STATUS_W-1:0] o_status;
    logic                o_out_valid;
    logic [SLOT_W-1:0]   o_out_slot;
    logic [ID_W-1:0]     o_out_id;
    logic [DATA_W-1:0]   o_out_data;
    logic [CNT_W-1:0]    o_overwrite_count;
    logic [CNT_W-1:0]    o_error_count;

    latest_value_tx_slot_arbiter_top #(
        .NUM_SLOTS(SLOTS)
    ) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_func            (i_func),
        .i_slot            (i_slot),
        .i_frame_id        (i_frame_id),
        .i_frame_data      (i_frame_data),
        .o_done            (o_done),
        .o_status          (o_status),
        .o_out_valid       (o_out_valid),
        .o_out_slot        (o_out_slot),
        .o_out_id          (o_out_id),
        .o_out_data        (o_out_data),
        .o_overwrite_count (o_overwrite_count),
        .o_error_count     (o_error_count)
    );

    // 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Arbiter model state: slot store, pending marks, round-robin pointer,
    // last transmitted frame (the one a reject puts back) and both counters.
    // ------------------------------------------------------------------
    logic [ID_W-1:0]   tb_slot_id   [SLOTS];
    logic [DATA_W-1:0] tb_slot_data [SLOTS];
    bit                tb_pend      [SLOTS];
    int                tb_rr_ptr = 0;
    bit                last_tx_valid = 1'b0;
    int                last_tx_slot = 0;
    logic [ID_W-1:0]   last_tx_id = '0;
    logic [DATA_W-1:0] last_tx_data = '0;
    logic [CNT_W-1:0]  tb_ovw_cnt = '0;
    logic [CNT_W-1:0]  tb_err_cnt = '0;

    t_arb_result pending_answers [$];
    int          mismatches = 0;
    bit          idle_on = 1'b1;

    // Applies one accepted request to the model and returns its result.
    function automatic t_arb_result arbitrate_request(input logic [FUNC_W-1:0] f,
                                                      input logic [SLOT_W-1:0] s,
                                                      input logic [ID_W-1:0]   id,
                                                      input logic [DATA_W-1:0] d);
        t_arb_result r;
        int          idx;
        int          found;
        bit          hit;
        r     = '0;
        hit   = 1'b0;
        found = 0;
        case (f)
            FUNC_SUBMIT: begin
                if (s >= SLOTS) begin
                    r.status = ST_BAD_SLOT;
                end else begin
                    if (tb_pend[s])
                        tb_ovw_cnt = tb_ovw_cnt + 1'b1;
                    tb_slot_id[s]   = id;
                    tb_slot_data[s] = d;
                    tb_pend[s]      = 1'b1;
                end
            end
            FUNC_PUMP: begin
                // first pending slot at or after the pointer, wrapping
                for (int k = 0; k < SLOTS; k++) begin
                    idx = (tb_rr_ptr + k) % SLOTS;
                    if (!hit && tb_pend[idx]) begin
                        hit   = 1'b1;
                        found = idx;
                    end
                end
                if (!hit) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.valid        = 1'b1;
                    r.slot         = SLOT_W'(found);
                    r.id           = tb_slot_id[found];
                    r.data         = tb_slot_data[found];
                    tb_pend[found] = 1'b0;
                    tb_rr_ptr      = (found + 1) % SLOTS;
                    last_tx_valid  = 1'b1;
                    last_tx_slot   = found;
                    last_tx_id     = r.id;
                    last_tx_data   = r.data;
                end
            end
            FUNC_REJECT: begin
                if (!last_tx_valid) begin
                    r.status = ST_NO_RESTORE;
                end else begin
                    // restored frame wins over anything submitted since
                    tb_slot_id[last_tx_slot]   = last_tx_id;
                    tb_slot_data[last_tx_slot] = last_tx_data;
                    tb_pend[last_tx_slot]      = 1'b1;
                    tb_err_cnt                 = tb_err_cnt + 1'b1;
                    last_tx_valid              = 1'b0;
                end
            end
            default: ;
        endcase
        r.ovw  = tb_ovw_cnt;
        r.errs = tb_err_cnt;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Monitor. Everything is sampled at the rising edge (pre-edge values),
    // so acceptance and results are seen exactly as the DUT sees them.
    // Results are checked before the request accepted at this same edge is
    // queued: a result in this cycle always belongs to an older request.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_arb_result got;
        t_arb_result want;
        if (i_rst_n === 1'b1) begin
            if (o_done === 1'b1) begin
                got = '{o_status, o_out_valid, o_out_slot, o_out_id, o_out_data,
                        o_overwrite_count, o_error_count};
                if (pending_answers.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want = pending_answers.pop_front();
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  got.status, want.status));
                    if (got.valid !== want.valid)
                        report_mismatch($sformatf("out_valid %b, want %b",
                                                  got.valid, want.valid));
                    if (got.slot !== want.slot)
                        report_mismatch($sformatf("out_slot %0d, want %0d",
                                                  got.slot, want.slot));
                    if (got.id !== want.id)
                        report_mismatch($sformatf("out_id %h, want %h",
                                                  got.id, want.id));
                    if (got.data !== want.data)
                        report_mismatch($sformatf("out_data %h, want %h",
                                                  got.data, want.data));
                    if (got.ovw !== want.ovw)
                        report_mismatch($sformatf("overwrite_count %0d, want %0d",
                                                  got.ovw, want.ovw));
                    if (got.errs !== want.errs)
                        report_mismatch($sformatf("error_count %0d, want %0d",
                                                  got.errs, want.errs));
                end
            end else if (o_done !== 1'b0) begin
                report_mismatch("o_done unknown");
            end
            if (start === 1'b1 && busy === 1'b0)
                pending_answers.push_back(arbitrate_request(i_func, i_slot,
                                                            i_frame_id, i_frame_data));
        end
    end

    // ------------------------------------------------------------------
    // Request driver. Start is left high on return so back-to-back requests
    // keep it asserted; only idle_cycles() and wait_for_drain() lower it.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [FUNC_W-1:0] f, input logic [SLOT_W-1:0] s,
                                input logic [ID_W-1:0] id, input logic [DATA_W-1:0] d);
        start        <= 1'b1;
        i_func       <= f;
        i_slot       <= s;
        i_frame_id   <= id;
        i_frame_data <= d;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // random sender gap: a burst of idle cycles of random length
    task automatic maybe_idle();
        if (idle_on && $urandom_range(0, 3) == 0)
            idle_cycles($urandom_range(1, 4));
    endtask

    // sender holds off until every outstanding result is back; the first
    // edge lets the monitor queue the request accepted just before
    task automatic wait_for_drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_answers.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // nothing emitted yet: reject has nothing to put back, pump finds nothing,
    // unused code is a no-op
    task automatic test_idle_state();
        send_request(FUNC_REJECT, 4'd0, '0, '0);
        send_request(FUNC_PUMP, 4'hF, '1, '1);
        send_request(FUNC_UNUSED, 4'h5, 11'h2AA, {4{16'hA5A5}});
    endtask

    task automatic test_bad_slot();
        send_request(FUNC_SUBMIT, 4'hF, '1, '1);
        send_request(FUNC_SUBMIT, SLOT_W'(SLOTS), 11'h123, 64'h0123_4567_89AB_CDEF);
    endtask

    // fill every slot with extreme ids / payloads, overwrite one, then pump
    // them all out in round-robin order and once more on empty
    task automatic test_fill_and_pump();
        send_request(FUNC_SUBMIT, 4'd0, '0, '0);
        send_request(FUNC_SUBMIT, 4'd1, '1, '1);
        send_request(FUNC_SUBMIT, 4'd2, 11'h555, {4{16'hAAAA}});
        send_request(FUNC_SUBMIT, SLOT_W'(SLOTS - 1), 11'h2AA, {4{16'h5555}});
        send_request(FUNC_SUBMIT, 4'd2, 11'h7F0, 64'hFEDC_BA98_7654_3210);
        repeat (SLOTS + 1) send_request(FUNC_PUMP, '0, '0, '0);
    endtask

    // reject puts back the last frame once; a second reject has nothing;
    // a reject after a newer submit to that slot restores the older frame
    task automatic test_reject();
        send_request(FUNC_REJECT, '0, '0, '0);
        send_request(FUNC_REJECT, '0, '0, '0);
        send_request(FUNC_PUMP, '0, '0, '0);
        send_request(FUNC_SUBMIT, SLOT_W'(SLOTS - 1), 11'h001, 64'h1);
        send_request(FUNC_REJECT, '0, '0, '0);
        send_request(FUNC_PUMP, '0, '0, '0);
    endtask

    // ------------------------------------------------------------------
    // Random traffic. Requests come in runs that lean toward filling or
    // toward draining, so several slots are pending at once and the pointer
    // wraps often; rejects follow pumps often enough to be meaningful.
    // ------------------------------------------------------------------
    task automatic send_random_request(input int fill_pct);
        int                pick;
        logic [FUNC_W-1:0] f;
        logic [SLOT_W-1:0] s;
        pick = $urandom_range(0, 99);
        if (pick < fill_pct)
            f = FUNC_SUBMIT;
        else if (pick < 86)
            f = FUNC_PUMP;
        else if (pick < 97)
            f = FUNC_REJECT;
        else
            f = FUNC_UNUSED;
        if (f != FUNC_SUBMIT)
            s = SLOT_W'($urandom);
        else if ($urandom_range(0, 9) == 0)
            s = SLOT_W'($urandom_range(SLOTS, 15));
        else
            s = SLOT_W'($urandom_range(0, SLOTS - 1));
        send_request(f, s, ID_W'($urandom), {$urandom, $urandom});
    endtask

    task automatic test_random_traffic(input int n);
        for (int i = 0; i < n; i++) begin
            send_random_request(((i / 12) % 2 == 0) ? 60 : 25);
            // stretches of 40 requests with and without sender gaps
            if ((i / 40) % 2 == 0)
                maybe_idle();
            if (i == n / 2)
                wait_for_drain();
        end
    endtask

    // back-to-back requests, no sender gaps at all
    task automatic test_streaming(input int n);
        idle_on = 1'b0;
        for (int i = 0; i < n; i++)
            send_random_request(((i / 8) % 2 == 0) ? 55 : 30);
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_func       <= FUNC_SUBMIT;
        i_slot       <= '0;
        i_frame_id   <= '0;
        i_frame_data <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_state();
        test_bad_slot();
        test_fill_and_pump();
        test_reject();
        test_random_traffic(600);
        test_streaming(100);

        // let the last results come out, then keep the clock running quietly to catch strays
        wait_for_drain();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // watchdog: stops a run that never finishes
    initial begin
        #4_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

// File: sim.f
rtl/lvtsa_pkg.sv
rtl/lvtsa_ram.sv
rtl/latest_value_tx_slot_arbiter_top.sv
tb/sv/tb_top.sv
